// ===== hdl/poa_pkg.sv =====
`default_nettype none

package poa_pkg;

    // coordinate and register widths
    localparam int COORD_W = 16;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 3;
    localparam int CMD_W   = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_X  = 3'd2;
    localparam logic [IDX_W-1:0] REG_START_Y  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DURATION = 3'd4;
    localparam logic [IDX_W-1:0] REG_REPEAT   = 3'd5;

    localparam logic [TIME_W-1:0] DURATION_RESET = 32'd1000000;

    // inverse cordic gain in q24
    localparam logic signed [24:0] GAIN_Q24 = 25'sd10188013;

    // cordic datapath widths
    localparam int XY_W = 44;
    localparam int Z_W  = 33;

    // commands from controller to datapath
    typedef struct packed {
        logic start;
        logic stop;
        logic update;
        logic div_step;
        logic mul;
        logic rot_step;
        logic finish;
        logic push;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic running;
    } t_dp_status;

    // arctangent of 2^-i in 32-bit turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/poa_ctrl.sv =====
`default_nettype none

module poa_ctrl #(
    parameter int PHASE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [poa_pkg::CMD_W-1:0] i_command,
    input  wire logic                    i_hold,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    input  wire poa_pkg::t_dp_status     i_status,
    output poa_pkg::t_dp_cmd             o_cmd,
    output logic [4:0]                   o_step
);
    import poa_pkg::*;

    localparam int MAX_STEPS = (PHASE_BITS > CORDIC_STEPS) ? PHASE_BITS : CORDIC_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_ROT,
        S_FIN,
        S_PUSH
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic              accept;
    logic              slot_free;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_step     = 5'(r_cnt);

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_START: begin
                            if (!i_status.running) begin
                                o_cmd.start = 1'b1;
                                n_state     = S_PUSH;
                            end
                        end
                        CMD_STOP: begin
                            o_cmd.stop = 1'b1;
                        end
                        CMD_UPDATE: begin
                            if (i_status.running && !i_hold) begin
                                o_cmd.update = 1'b1;
                                n_cnt        = '0;
                                n_state      = S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(PHASE_BITS - 1)) begin
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
                n_state   = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot_step = 1'b1;
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_PUSH;
            end
            S_PUSH: begin
                if (slot_free) begin
                    o_cmd.push  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/poa_dpath.sv =====
`default_nettype none

module poa_dpath #(
    parameter int PHASE_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [poa_pkg::IDX_W-1:0]         i_cfg_index,
    input  wire logic [31:0]                       i_cfg_data,
    input  wire logic [poa_pkg::TIME_W-1:0]        i_frame_time,
    input  wire poa_pkg::t_dp_cmd                  i_cmd,
    input  wire logic [4:0]                        i_step,
    output poa_pkg::t_dp_status                    o_status,
    output logic signed [poa_pkg::COORD_W-1:0]     o_pos_x,
    output logic signed [poa_pkg::COORD_W-1:0]     o_pos_y,
    output logic                                   o_finished
);
    import poa_pkg::*;

    // configuration
    logic signed [COORD_W-1:0] r_center_x, r_center_y, r_start_x, r_start_y;
    logic [TIME_W-1:0]         r_duration;
    logic                      r_repeat;

    // orbit state
    logic [TIME_W-1:0]         r_elapsed;
    logic                      r_running;
    logic                      r_full;

    // divider
    logic [TIME_W-1:0]         r_rem;
    logic [PHASE_BITS-1:0]     r_quot;

    // cordic
    logic signed [XY_W-1:0]    r_x, r_y;
    logic signed [Z_W-1:0]     r_z;

    // pending result and output word
    logic signed [COORD_W-1:0] r_pend_x, r_pend_y;
    logic                      r_pend_fin;
    logic signed [COORD_W-1:0] r_pos_x, r_pos_y;
    logic                      r_fin;

    logic [TIME_W:0]           sum;
    logic [TIME_W-1:0]         sat_sum;
    logic [TIME_W:0]           rem_sh;
    logic                      rem_ge;
    logic [31:0]               angle;
    logic signed [COORD_W:0]   dx, dy;
    logic signed [41:0]        px, py;
    logic signed [XY_W-1:0]    mx, my;
    logic signed [XY_W-1:0]    xs, ys;
    logic signed [Z_W-1:0]     atan_z;
    logic signed [XY_W-1:0]    rx, ry;
    logic signed [XY_W-1:0]    ox, oy;

    assign o_status.running = r_running;
    assign o_pos_x    = r_pos_x;
    assign o_pos_y    = r_pos_y;
    assign o_finished = r_fin;

    // saturating elapsed time
    assign sum     = {1'b0, r_elapsed} + {1'b0, i_frame_time};
    assign sat_sum = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    // restoring divide step
    assign rem_sh = {r_rem, 1'b0};
    assign rem_ge = (rem_sh >= {1'b0, r_duration});

    // angle in 32-bit turn units
    assign angle = r_full ? 32'd0 : {r_quot, {(32 - PHASE_BITS){1'b0}}};

    // offset times inverse gain
    assign dx = (COORD_W + 1)'(r_start_x) - (COORD_W + 1)'(r_center_x);
    assign dy = (COORD_W + 1)'(r_start_y) - (COORD_W + 1)'(r_center_y);
    assign px = dx * GAIN_Q24;
    assign py = dy * GAIN_Q24;
    assign mx = XY_W'(px);
    assign my = XY_W'(py);

    // cordic step terms
    assign xs     = r_x >>> i_step;
    assign ys     = r_y >>> i_step;
    assign atan_z = Z_W'(atan_turn(i_step));

    // rounding and center add
    assign rx = (r_x + XY_W'(64'sd8388608)) >>> 24;
    assign ry = (r_y + XY_W'(64'sd8388608)) >>> 24;
    assign ox = XY_W'(r_center_x) + rx;
    assign oy = XY_W'(r_center_y) + ry;

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_duration <= DURATION_RESET;
            r_repeat   <= 1'b0;
            r_elapsed  <= '0;
            r_running  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CENTER_X: r_center_x <= i_cfg_data[COORD_W-1:0];
                    REG_CENTER_Y: r_center_y <= i_cfg_data[COORD_W-1:0];
                    REG_START_X:  r_start_x  <= i_cfg_data[COORD_W-1:0];
                    REG_START_Y:  r_start_y  <= i_cfg_data[COORD_W-1:0];
                    REG_DURATION: r_duration <= i_cfg_data[TIME_W-1:0];
                    REG_REPEAT:   r_repeat   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_running <= 1'b1;
                r_elapsed <= '0;
            end
            if (i_cmd.stop) begin
                r_running <= 1'b0;
            end
            if (i_cmd.update) begin
                r_elapsed <= sat_sum;
            end
            // end of orbit
            if (i_cmd.finish && r_full) begin
                if (!r_repeat) begin
                    r_running <= 1'b0;
                    r_elapsed <= r_duration;
                end else begin
                    r_elapsed <= '0;
                end
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pend_x   <= r_start_x;
            r_pend_y   <= r_start_y;
            r_pend_fin <= 1'b0;
        end
        if (i_cmd.update) begin
            r_full <= (sat_sum >= r_duration);
            r_rem  <= sat_sum;
            r_quot <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? TIME_W'(rem_sh - {1'b0, r_duration}) : rem_sh[TIME_W-1:0];
            r_quot <= {r_quot[PHASE_BITS-2:0], rem_ge};
        end
        // quadrant pre-rotation
        if (i_cmd.mul) begin
            r_z <= Z_W'(angle[29:0]);
            case (angle[31:30])
                2'd1:    begin r_x <= -my; r_y <= mx;  end
                2'd2:    begin r_x <= -mx; r_y <= -my; end
                2'd3:    begin r_x <= my;  r_y <= -mx; end
                default: begin r_x <= mx;  r_y <= my;  end
            endcase
        end
        if (i_cmd.rot_step) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_z;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_z;
            end
        end
        if (i_cmd.finish) begin
            r_pend_x   <= ox[COORD_W-1:0];
            r_pend_y   <= oy[COORD_W-1:0];
            r_pend_fin <= r_full && !r_repeat;
        end
        if (i_cmd.push) begin
            r_pos_x <= r_pend_x;
            r_pos_y <= r_pend_y;
            r_fin   <= r_pend_fin;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/point_orbit_animator_core.sv =====
// result path: a start word goes through S_PUSH to the output registers, an update word
// through S_DIV, S_MUL, S_ROT, S_FIN and S_PUSH; S_PUSH waits while the output word is stalled
// throughput: one word at a time; an update runs the bit-serial divider and then the
// shared cordic stage before the next word is taken
// stop, paused and ignored words give no result
// reset: i_rst_n synchronous active low, clears control, elapsed time and registers (1 ms)
`default_nettype none

module point_orbit_animator_core #(
    parameter int PHASE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [poa_pkg::IDX_W-1:0]          i_cfg_index,
    input  wire logic [31:0]                        i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [poa_pkg::CMD_W-1:0]          i_command,
    input  wire logic [poa_pkg::TIME_W-1:0]         i_frame_time,
    input  wire logic                               i_hold,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [poa_pkg::COORD_W-1:0]      o_pos_x,
    output logic signed [poa_pkg::COORD_W-1:0]      o_pos_y,
    output logic                                    o_finished
);
    import poa_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic [4:0] step;

    assign o_cfg_ready = 1'b1;

    // sequencer
    poa_ctrl #(
        .PHASE_BITS   (PHASE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_hold      (i_hold),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_step      (step)
    );

    // divider, cordic and registers
    poa_dpath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_frame_time (i_frame_time),
        .i_cmd        (cmd),
        .i_step       (step),
        .o_status     (status),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_finished   (o_finished)
    );

endmodule

`default_nettype wire

// ===== test/point_orbit_animator_core_chk.sv =====
`default_nettype none

module point_orbit_animator_core_chk (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_ready,
    input  wire logic [poa_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]                i_cfg_data,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire logic [poa_pkg::CMD_W-1:0]  i_command,
    input  wire logic [31:0]                i_frame_time,
    input  wire logic                       i_hold,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic [15:0]                i_pos_x,
    input  wire logic [15:0]                i_pos_y,
    input  wire logic                       i_finished,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_finishes
);
    timeunit 1ns;
    timeprecision 1ps;

    import poa_pkg::*;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        fin;
    } t_pos;

    // arctangent of 2^-i as a fraction of a 32-bit turn
    localparam logic [31:0] ARCTAN_TURN [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };
    localparam longint INV_GAIN = 64'sd10188013;

    logic [15:0] m_cx, m_cy, m_sx, m_sy;
    logic [31:0] m_dur;
    logic        m_rep;
    logic [31:0] m_elapsed;
    logic        m_run;
    t_pos        pos_q[$];

    // expected position, if any, for one accepted word
    task automatic orbit_step(input logic [1:0] cmd, input logic [31:0] ft, input logic hld);
        logic [32:0] sum;
        logic [63:0] phase;
        logic [31:0] angle;
        longint      cx, cy, x, y, z, t, xs, ys, rx, ry;
        t_pos        p;
        if (cmd == CMD_START) begin
            if (!m_run) begin
                m_run     = 1'b1;
                m_elapsed = '0;
                p.x = m_sx;
                p.y = m_sy;
                p.fin = 1'b0;
                pos_q.push_back(p);
            end
        end else if (cmd == CMD_STOP) begin
            m_run = 1'b0;
        end else if (cmd == CMD_UPDATE && m_run && !hld) begin
            sum = {1'b0, m_elapsed} + {1'b0, ft};
            m_elapsed = sum[32] ? 32'hFFFFFFFF : sum[31:0];
            angle = '0;
            if (m_elapsed < m_dur) begin
                phase = {16'b0, m_elapsed, 16'b0} / {32'b0, m_dur};
                angle = {phase[15:0], 16'b0};
            end
            cx = longint'($signed(m_cx));
            cy = longint'($signed(m_cy));
            x = (longint'($signed(m_sx)) - cx) * INV_GAIN;
            y = (longint'($signed(m_sy)) - cy) * INV_GAIN;
            z = longint'({34'b0, angle[29:0]});
            // exact quarter turns first
            case (angle[31:30])
                2'd1: begin t = x; x = -y; y = t; end
                2'd2: begin x = -x; y = -y; end
                2'd3: begin t = x; x = y; y = -t; end
                default: ;
            endcase
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - longint'(ARCTAN_TURN[i]);
                end else begin
                    x = x + ys; y = y - xs; z = z + longint'(ARCTAN_TURN[i]);
                end
            end
            rx = (x + (64'sd1 <<< 23)) >>> 24;
            ry = (y + (64'sd1 <<< 23)) >>> 24;
            t = cx + rx;
            p.x = t[15:0];
            t = cy + ry;
            p.y = t[15:0];
            p.fin = 1'b0;
            if (m_elapsed >= m_dur) begin
                if (!m_rep) begin
                    m_run     = 1'b0;
                    m_elapsed = m_dur;
                    p.fin     = 1'b1;
                end else begin
                    m_elapsed = '0;
                end
            end
            pos_q.push_back(p);
        end
    endtask

    // watch all three channels
    always @(posedge i_clk) begin
        t_pos e;
        if (!i_rst_n) begin
            m_cx = '0; m_cy = '0; m_sx = '0; m_sy = '0;
            m_dur = DURATION_RESET;
            m_rep = 1'b0;
            m_elapsed = '0;
            m_run = 1'b0;
            pos_q.delete();
            o_errors <= 0;
            o_results <= 0;
            o_finishes <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CENTER_X: m_cx  = i_cfg_data[15:0];
                    REG_CENTER_Y: m_cy  = i_cfg_data[15:0];
                    REG_START_X:  m_sx  = i_cfg_data[15:0];
                    REG_START_Y:  m_sy  = i_cfg_data[15:0];
                    REG_DURATION: m_dur = i_cfg_data;
                    REG_REPEAT:   m_rep = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (i_finished) o_finishes <= o_finishes + 1;
                if (pos_q.size() == 0) begin
                    $display("%0t: unexpected word x=%0d y=%0d fin=%0b", $realtime,
                             $signed(i_pos_x), $signed(i_pos_y), i_finished);
                    o_errors <= o_errors + 1;
                end else begin
                    e = pos_q.pop_front();
                    if (e.x !== i_pos_x || e.y !== i_pos_y || e.fin !== i_finished) begin
                        $display("%0t: mismatch expected x=%0d y=%0d fin=%0b, got x=%0d y=%0d fin=%0b",
                                 $realtime, $signed(e.x), $signed(e.y), e.fin,
                                 $signed(i_pos_x), $signed(i_pos_y), i_finished);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                orbit_step(i_command, i_frame_time, i_hold);
        end
        o_pending <= pos_q.size();
    end

endmodule

`default_nettype wire

// ===== test/point_orbit_animator_core_tb.sv =====
`default_nettype none

module point_orbit_animator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import poa_pkg::*;

    localparam logic [1:0] CMD_BAD = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_index;
    logic [31:0]         i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command;
    logic [TIME_W-1:0]   i_frame_time;
    logic                i_hold;
    logic                o_out_valid;
    logic                i_out_stall;
    logic signed [15:0]  o_pos_x;
    logic signed [15:0]  o_pos_y;
    logic                o_finished;

    int errors, pending, results, finishes;
    int words_sent;
    int phase_no;
    int cycle_cnt;
    int holdoff_left;
    logic [31:0] cur_dur;

    point_orbit_animator_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_frame_time (i_frame_time),
        .i_hold       (i_hold),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_finished   (o_finished)
    );

    point_orbit_animator_core_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_frame_time (i_frame_time),
        .i_hold       (i_hold),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_pos_x      (o_pos_x),
        .i_pos_y      (o_pos_y),
        .i_finished   (o_finished),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_results    (results),
        .o_finishes   (finishes)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // receiver: random stalls, quiet stretches and periodic long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            cycle_cnt <= 0;
            holdoff_left <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if (holdoff_left > 0) begin
                i_out_stall <= 1'b1;
                holdoff_left <= holdoff_left - 1;
            end else if (cycle_cnt % 30000 == 20000) begin
                i_out_stall <= 1'b1;
                holdoff_left <= 800;
            end else if ((cycle_cnt / 3000) % 4 == 1) begin
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 199) == 0) begin
                i_out_stall <= 1'b1;
                holdoff_left <= $urandom_range(10, 60);
            end else begin
                i_out_stall <= ($urandom_range(0, 9) < 3);
            end
        end
    end

    // run limit
    initial begin
        #30ms;
        $display("[point_orbit_animator_core] ERROR");
        $finish;
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_DURATION) cur_dur = data;
    endtask

    task automatic load_orbit(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] sx, input logic [15:0] sy,
                              input logic [31:0] dur, input logic rep);
        write_reg(REG_CENTER_X, {16'($urandom_range(0, 65535)), cx});
        write_reg(REG_CENTER_Y, {16'h0, cy});
        write_reg(REG_START_X, {16'hFFFF, sx});
        write_reg(REG_START_Y, {16'($urandom_range(0, 65535)), sy});
        write_reg(REG_DURATION, dur);
        write_reg(REG_REPEAT, {31'($urandom), rep});
    endtask

    // stop offering and wait for the block to drain before touching registers
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // offer one word, then an optional gap
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] ft, input logic hld);
        int gap, r;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_frame_time <= ft;
        i_hold       <= hld;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        r = $urandom_range(0, 99);
        if (phase_no % 4 == 3) gap = 0;
        else if (r < 50) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // frame time scaled to the current duration, now and then any value
    function automatic logic [31:0] pick_frame_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return $urandom;
        if (r < 9) return 32'd0;
        if (cur_dur < 3) return $urandom_range(0, 3);
        return cur_dur / $urandom_range(3, 40) + $urandom_range(0, 7);
    endfunction

    task automatic random_words(input int count);
        int n, k;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise
                send_word(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
                n++;
            end else begin
                send_word(CMD_START, $urandom, 1'($urandom_range(0, 1)));
                n++;
                k = $urandom_range(3, 30);
                for (int j = 0; j < k; j++) begin
                    send_word(CMD_UPDATE, pick_frame_time(), ($urandom_range(0, 9) == 0));
                    n++;
                end
                if ($urandom_range(0, 2) == 0) begin
                    send_word(CMD_STOP, $urandom, 1'($urandom_range(0, 1)));
                    n++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_command    <= CMD_STOP;
        i_frame_time <= '0;
        i_hold       <= 1'b0;
        words_sent = 0;
        phase_no = 0;
        cur_dur = DURATION_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset registers first, then corner cases
        send_word(CMD_UPDATE, 32'd5, 1'b0);
        send_word(CMD_START, 32'd0, 1'b0);
        send_word(CMD_UPDATE, 32'd250000, 1'b0);
        send_word(CMD_START, 32'd0, 1'b0);
        drain();
        load_orbit(16'h0064, 16'hFF38, 16'h01F4, 16'h0000, 32'd1000, 1'b0);
        send_word(CMD_UPDATE, 32'd10, 1'b0);
        send_word(CMD_START, 32'hFFFFFFFF, 1'b1);
        send_word(CMD_UPDATE, 32'd250, 1'b1);
        send_word(CMD_UPDATE, 32'd0, 1'b0);
        send_word(CMD_UPDATE, 32'd250, 1'b0);
        send_word(CMD_UPDATE, 32'd250, 1'b0);
        send_word(CMD_UPDATE, 32'd250, 1'b0);
        send_word(CMD_BAD, 32'hFFFFFFFF, 1'b0);
        send_word(CMD_UPDATE, 32'd249, 1'b0);
        send_word(CMD_UPDATE, 32'd1, 1'b0);
        send_word(CMD_UPDATE, 32'd1, 1'b0);
        send_word(CMD_START, 32'd0, 1'b0);
        send_word(CMD_STOP, 32'd0, 1'b0);
        send_word(CMD_UPDATE, 32'd100, 1'b0);
        send_word(CMD_START, 32'd0, 1'b0);
        send_word(CMD_UPDATE, 32'hFFFFFFFF, 1'b0);
        send_word(CMD_START, 32'd0, 1'b0);
        send_word(CMD_UPDATE, 32'hFFFFFFFF, 1'b0);
        drain();

        // random phases over several register settings
        for (phase_no = 1; phase_no <= 12; phase_no++) begin
            case (phase_no)
                1: load_orbit(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 32'd1, 1'b0);
                2: load_orbit(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                              32'hFFFFFFFF, 1'b1);
                3: load_orbit(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              32'd0, 1'b1);
                4: load_orbit(16'h0000, 16'h0000, 16'h8000, 16'h0000, 32'd1, 1'b1);
                5: load_orbit(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              $urandom, 1'($urandom_range(0, 1)));
                default: load_orbit(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), $urandom_range(1, 5000),
                                    1'($urandom_range(0, 1)));
            endcase
            random_words(150);
            i_in_valid <= 1'b0;
            drain();
        end

        $display("sent %0d words over 14 register settings, checked %0d positions",
                 words_sent, results);
        $display("%0d orbits reported as finished", finishes);
        if (errors == 0) begin
            $display("[point_orbit_animator_core] OK");
        end else begin
            $display("[point_orbit_animator_core] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/poa_pkg.sv
hdl/poa_ctrl.sv
hdl/poa_dpath.sv
hdl/point_orbit_animator_core.sv
test/point_orbit_animator_core_chk.sv
test/point_orbit_animator_core_tb.sv
